/* src/pmsel_pkg.sv */
// ----------------------------------------------------------------------------
// pmsel_pkg
// Shared codes and payload types for the pedal mode selector.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsel_pkg;

   localparam int ModeW = 3;
   localparam int LedW  = 3;
   localparam int CmdW  = 2;
   localparam int FailW = 7;

   // reported / target mode codes
   localparam logic [ModeW-1:0] MODE_NONE   = 3'd0;
   localparam logic [ModeW-1:0] MODE_NORMAL = 3'd1;
   localparam logic [ModeW-1:0] MODE_FAST   = 3'd2;
   localparam logic [ModeW-1:0] MODE_PARK   = 3'd3;
   localparam logic [ModeW-1:0] MODE_LOCK   = 3'd4;
   localparam logic [ModeW-1:0] MODE_OTHER  = 3'd5;

   // led pattern codes
   localparam logic [LedW-1:0] LED_ERROR   = 3'd0;
   localparam logic [LedW-1:0] LED_PENDING = 3'd1;
   localparam logic [LedW-1:0] LED_PARK    = 3'd2;
   localparam logic [LedW-1:0] LED_OFF     = 3'd3;
   localparam logic [LedW-1:0] LED_ON      = 3'd4;

   // output pulse commands
   localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
   localparam logic [CmdW-1:0] CMD_SHORT = 2'd1;
   localparam logic [CmdW-1:0] CMD_LONG  = 2'd2;
   localparam logic [CmdW-1:0] CMD_HOLD  = 2'd3;

   localparam logic [FailW-1:0] FAIL_SAT       = 7'd127;
   localparam logic [FailW-1:0] MAX_FAILS_RST  = 7'd80;

   typedef struct packed {
      logic [ModeW-1:0] current_mode;
      logic             link_up;
      logic             button_click;
      logic             button_double;
      logic             button_multi;
      logic             emergency_click;
      logic             sport_mode;
   } req_word_type;

   typedef struct packed {
      logic [ModeW-1:0] target_mode_out;
      logic [LedW-1:0]  led_pattern;
      logic [CmdW-1:0]  output_command;
      logic             error_active;
   } rsp_word_type;

endpackage

`default_nettype wire

/* src/pmsel_core.sv */
// ----------------------------------------------------------------------------
// pmsel_core
// Mode selector state, failure limit register and the per-tick decision
// logic. State advances on each tick that step_en marks.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsel_core
   import pmsel_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cfg_we,
   input  wire logic [FailW-1:0] cfg_data,
   input  wire logic         step_en,
   input  wire req_word_type req_word,
   output rsp_word_type      rsp_word
);

   logic [FailW-1:0] max_fails_ff;
   logic [ModeW-1:0] target_ff, target_in;
   logic             first_ff, first_in;
   logic             await_ff, await_in;
   logic [ModeW-1:0] remem_ff, remem_in;
   logic [ModeW-1:0] clret_ff, clret_in;
   logic [FailW-1:0] fails_ff, fails_in;

   logic [ModeW-1:0] cur;
   logic             err_now;
   logic             ev_lock;
   logic             stop;
   logic [LedW-1:0]  led;
   logic [CmdW-1:0]  cmd;

   always_comb begin
      cur     = (req_word.current_mode > MODE_OTHER) ? MODE_OTHER : req_word.current_mode;
      err_now = fails_ff >= max_fails_ff;
      ev_lock = req_word.button_multi | req_word.emergency_click;

      // led comes from state before this tick's decisions
      if (err_now) begin
         led = LED_ERROR;
      end else if (cur != target_ff) begin
         led = LED_PENDING;
      end else if (target_ff == MODE_PARK) begin
         led = LED_PARK;
      end else if (target_ff == MODE_FAST) begin
         led = LED_ON;
      end else begin
         led = LED_OFF;
      end

      target_in = target_ff;
      first_in  = first_ff;
      await_in  = await_ff;
      remem_in  = remem_ff;
      clret_in  = clret_ff;
      fails_in  = fails_ff;
      cmd       = CMD_NONE;
      stop      = 1'b0;

      if (req_word.link_up && cur != MODE_NONE) begin
         if (first_ff) begin
            if (cur == MODE_PARK || cur == MODE_LOCK || cur == MODE_NORMAL) begin
               target_in = cur;
            end else begin
               target_in = MODE_NORMAL;
            end
            first_in = 1'b0;
         end

         if (err_now) begin
            if (req_word.button_click) begin
               fails_in  = '0;
               await_in  = 1'b0;
               remem_in  = MODE_NONE;
               target_in = MODE_NORMAL;
            end
            cmd = CMD_HOLD;
         end else if (target_in != cur) begin
            if (cur != remem_ff && !await_ff) begin
               cmd = (target_in == MODE_PARK || target_in == MODE_LOCK) ? CMD_LONG
                                                                        : CMD_SHORT;
               remem_in = cur;
               await_in = 1'b1;
               fails_in = '0;
            end else if (cur == remem_ff && await_ff) begin
               await_in = 1'b0;
            end else if (fails_ff < FAIL_SAT) begin
               fails_in = fails_ff + 1'b1;
            end
         end else begin
            if (!req_word.sport_mode) begin
               if (clret_ff != MODE_NONE) begin
                  target_in = clret_ff;
                  clret_in  = MODE_NONE;
               end
            end else begin
               if (ev_lock) begin
                  target_in = MODE_LOCK;
               end
               // a pending clutch return holds off everything below
               if (clret_ff != MODE_NONE) begin
                  stop = 1'b1;
               end
            end

            if (!stop) begin
               if (cur == MODE_LOCK) begin
                  if (ev_lock) begin
                     target_in = MODE_NORMAL;
                  end
               end else if (cur == MODE_PARK) begin
                  if (req_word.sport_mode) begin
                     target_in = MODE_NORMAL;
                     clret_in  = MODE_PARK;
                  end else begin
                     if (req_word.button_double) begin
                        target_in = MODE_NORMAL;
                     end
                     if (req_word.emergency_click) begin
                        target_in = MODE_LOCK;
                     end
                  end
               end else begin
                  if (req_word.sport_mode && cur == MODE_NORMAL) begin
                     target_in = MODE_FAST;
                     clret_in  = MODE_NORMAL;
                  end else if (req_word.button_click) begin
                     target_in = (cur == MODE_NORMAL) ? MODE_FAST : MODE_NORMAL;
                  end else if (req_word.button_double) begin
                     target_in = MODE_PARK;
                  end else if (ev_lock) begin
                     target_in = MODE_LOCK;
                  end
               end
            end
         end
      end

      rsp_word.target_mode_out = target_in;
      rsp_word.led_pattern     = led;
      rsp_word.output_command  = cmd;
      rsp_word.error_active    = fails_in >= max_fails_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fails_ff <= MAX_FAILS_RST;
         target_ff    <= MODE_NORMAL;
         first_ff     <= 1'b1;
         await_ff     <= 1'b0;
         remem_ff     <= MODE_NONE;
         clret_ff     <= MODE_NONE;
         fails_ff     <= '0;
      end else begin
         if (cfg_we) begin
            max_fails_ff <= cfg_data;
         end
         if (step_en) begin
            target_ff <= target_in;
            first_ff  <= first_in;
            await_ff  <= await_in;
            remem_ff  <= remem_in;
            clret_ff  <= clret_in;
            fails_ff  <= fails_in;
         end
      end
   end

   chk_target_range : assert property (@(posedge clock) disable iff (reset)
      (target_ff >= MODE_NORMAL && target_ff <= MODE_LOCK))
      else $error("kept target mode out of range");

   chk_fails_hold : assert property (@(posedge clock) disable iff (reset)
      !step_en && !cfg_we |=> $stable(fails_ff) && $stable(target_ff))
      else $error("state moved without a tick");

   chk_first_run : assert property (@(posedge clock) disable iff (reset)
      !first_ff |=> !first_ff)
      else $error("first-run flag came back");

endmodule

`default_nettype wire

/* src/pedal_mode_selector_fsm_top.sv */
// Path: a word accepted on req passes the input register, then decision logic
// into the result register, and is offered on rsp from the result register.
// Throughput: one word per cycle; the result register drains while the
// input register refills, so only a stalled rsp holds back req.
// Reset: synchronous, active high; target mode normal, first-run set, failure
// count zero, failure limit 80.
// ----------------------------------------------------------------------------
// pedal_mode_selector_fsm_top
// Pedal mode selector with input register, decision core and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_mode_selector_fsm_top
   import pmsel_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ModeW-1:0] req_current_mode,
   input  wire logic             req_link_up,
   input  wire logic             req_button_click,
   input  wire logic             req_button_double,
   input  wire logic             req_button_multi,
   input  wire logic             req_emergency_click,
   input  wire logic             req_sport_mode,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [ModeW-1:0]      rsp_target_mode_out,
   output logic [LedW-1:0]       rsp_led_pattern,
   output logic [CmdW-1:0]       rsp_output_command,
   output logic                  rsp_error_active,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [FailW-1:0] csr_wdata
);

   logic         in_vld_ff;
   req_word_type in_word_ff;
   logic         out_vld_ff;
   rsp_word_type out_word_ff;
   rsp_word_type core_rsp;
   logic         move;
   logic         in_take;

   // the held word moves on when the result register is empty or draining
   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign in_take   = req_valid && !req_stall;
   assign req_stall = in_vld_ff && !move;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_take) begin
            in_vld_ff <= 1'b1;
         end else if (move) begin
            in_vld_ff <= 1'b0;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff.current_mode    <= req_current_mode;
         in_word_ff.link_up         <= req_link_up;
         in_word_ff.button_click    <= req_button_click;
         in_word_ff.button_double   <= req_button_double;
         in_word_ff.button_multi    <= req_button_multi;
         in_word_ff.emergency_click <= req_emergency_click;
         in_word_ff.sport_mode      <= req_sport_mode;
      end
      if (move) begin
         out_word_ff <= core_rsp;
      end
   end

   pmsel_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg_we   (csr_valid && csr_ready),
      .cfg_data (csr_wdata),
      .step_en  (move),
      .req_word (in_word_ff),
      .rsp_word (core_rsp)
   );

   assign rsp_valid           = out_vld_ff;
   assign rsp_target_mode_out = out_word_ff.target_mode_out;
   assign rsp_led_pattern     = out_word_ff.led_pattern;
   assign rsp_output_command  = out_word_ff.output_command;
   assign rsp_error_active    = out_word_ff.error_active;

   chk_in_kept : assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !move |=> in_vld_ff)
      else $error("held request word dropped");

   chk_out_drain : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_stall && !move |=> !out_vld_ff)
      else $error("result word repeated");

   chk_clear_normal : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_word_ff.output_command == CMD_HOLD && !out_word_ff.error_active
      |-> out_word_ff.target_mode_out == MODE_NORMAL)
      else $error("error cleared without return to normal");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pedal mode selector.
// A directed table runs first: reset values, first-run mode pickup, the
// feedback handshake, clutch sport handling, out-of-range mode codes and
// error latch and clear. Random ticks follow, over several failure limits.
// Most random ticks have a pedal that follows the target mode; the rest are
// noise. Each result word is checked against its directed row or a cycle-level
// predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmsel_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          N_PHASES    = 8;
   localparam int          PHASE_TICKS = 205;

   // event flag bits, in payload order after current_mode
   localparam logic [5:0] EV_NONE  = 6'b000000;
   localparam logic [5:0] EV_LINK  = 6'b100000;
   localparam logic [5:0] EV_CLICK = 6'b010000;
   localparam logic [5:0] EV_DBL   = 6'b001000;
   localparam logic [5:0] EV_MULTI = 6'b000100;
   localparam logic [5:0] EV_EMERG = 6'b000010;
   localparam logic [5:0] EV_SPORT = 6'b000001;
   localparam logic [5:0] EV_ALL   = 6'b111111;

   typedef struct packed {
      bit               wr;
      logic [FailW-1:0] lim;
      req_word_type     req;
      bit               chk;
      rsp_word_type     rsp;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [ModeW-1:0] req_current_mode;
   logic             req_link_up;
   logic             req_button_click;
   logic             req_button_double;
   logic             req_button_multi;
   logic             req_emergency_click;
   logic             req_sport_mode;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [ModeW-1:0] rsp_target_mode_out;
   logic [LedW-1:0]  rsp_led_pattern;
   logic [CmdW-1:0]  rsp_output_command;
   logic             rsp_error_active;
   logic             csr_valid;
   logic             csr_ready;
   logic [FailW-1:0] csr_wdata;

   pedal_mode_selector_fsm_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_current_mode    (req_current_mode),
      .req_link_up         (req_link_up),
      .req_button_click    (req_button_click),
      .req_button_double   (req_button_double),
      .req_button_multi    (req_button_multi),
      .req_emergency_click (req_emergency_click),
      .req_sport_mode      (req_sport_mode),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_target_mode_out (rsp_target_mode_out),
      .rsp_led_pattern     (rsp_led_pattern),
      .rsp_output_command  (rsp_output_command),
      .rsp_error_active    (rsp_error_active),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   // predicted selector state
   logic [ModeW-1:0] sel_target;
   bit               sel_first;
   bit               sel_waiting;
   logic [ModeW-1:0] sel_remembered;
   logic [ModeW-1:0] sel_return;
   logic [FailW-1:0] sel_fails;
   logic [FailW-1:0] sel_limit;

   rsp_word_type rsp_due_q[$];
   dir_row_type  dir_rows[$];
   bit           quiet;
   int           n_fail;
   int           n_ticks;
   int           n_checked;
   int           n_hold;
   int           n_latched;
   int           n_cfg;
   int unsigned  cycle_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_cnt,
                  rsp_due_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // control decisions of one linked tick; returns the pulse command
   function automatic logic [CmdW-1:0] run_control(input logic [ModeW-1:0] cur,
                                                   input req_word_type w);
      logic to_lock;
      to_lock = w.button_multi | w.emergency_click;
      if (sel_first) begin
         if (cur == MODE_PARK || cur == MODE_LOCK || cur == MODE_NORMAL)
            sel_target = cur;
         else
            sel_target = MODE_NORMAL;
         sel_first = 1'b0;
      end
      if (sel_fails >= sel_limit) begin
         if (w.button_click) begin
            sel_fails = '0;
            sel_waiting = 1'b0;
            sel_remembered = MODE_NONE;
            sel_target = MODE_NORMAL;
         end
         return CMD_HOLD;
      end
      if (sel_target != cur) begin
         if (cur != sel_remembered && !sel_waiting) begin
            sel_remembered = cur;
            sel_waiting = 1'b1;
            sel_fails = '0;
            return (sel_target == MODE_PARK || sel_target == MODE_LOCK) ?
                   CMD_LONG : CMD_SHORT;
         end else if (cur == sel_remembered && sel_waiting) begin
            sel_waiting = 1'b0;
         end else if (sel_fails < FAIL_SAT) begin
            sel_fails = sel_fails + 1'b1;
         end
         return CMD_NONE;
      end
      if (!w.sport_mode) begin
         if (sel_return != MODE_NONE) begin
            sel_target = sel_return;
            sel_return = MODE_NONE;
         end
      end else begin
         if (to_lock) sel_target = MODE_LOCK;
         if (sel_return != MODE_NONE) return CMD_NONE;
      end
      if (cur == MODE_LOCK) begin
         if (to_lock) sel_target = MODE_NORMAL;
      end else if (cur == MODE_PARK) begin
         if (w.sport_mode) begin
            sel_target = MODE_NORMAL;
            sel_return = MODE_PARK;
            return CMD_NONE;
         end
         if (w.button_double) sel_target = MODE_NORMAL;
         if (w.emergency_click) sel_target = MODE_LOCK;
      end else begin
         if (w.sport_mode && cur == MODE_NORMAL) begin
            sel_target = MODE_FAST;
            sel_return = MODE_NORMAL;
         end else if (w.button_click) begin
            sel_target = (cur == MODE_NORMAL) ? MODE_FAST : MODE_NORMAL;
         end else if (w.button_double) begin
            sel_target = MODE_PARK;
         end else if (to_lock) begin
            sel_target = MODE_LOCK;
         end
      end
      return CMD_NONE;
   endfunction

   // full tick: led from the entry state, then the decisions, then the word
   function automatic rsp_word_type decide_tick(input req_word_type w);
      logic [ModeW-1:0] cur;
      rsp_word_type     r;
      cur = (w.current_mode > MODE_OTHER) ? MODE_OTHER : w.current_mode;
      if (sel_fails >= sel_limit)       r.led_pattern = LED_ERROR;
      else if (cur != sel_target)       r.led_pattern = LED_PENDING;
      else if (sel_target == MODE_PARK) r.led_pattern = LED_PARK;
      else if (sel_target == MODE_FAST) r.led_pattern = LED_ON;
      else                              r.led_pattern = LED_OFF;
      r.output_command = CMD_NONE;
      if (w.link_up && cur != MODE_NONE) r.output_command = run_control(cur, w);
      r.target_mode_out = sel_target;
      r.error_active = (sel_fails >= sel_limit);
      return r;
   endfunction

   function automatic dir_row_type drow(input bit wr, input logic [FailW-1:0] lim,
                                        input logic [ModeW-1:0] cur, input logic [5:0] ev,
                                        input bit chk, input logic [ModeW-1:0] tg,
                                        input logic [LedW-1:0] ld, input logic [CmdW-1:0] cm,
                                        input logic er);
      dir_row_type d;
      d.wr = wr;
      d.lim = lim;
      d.req = req_word_type'({cur, ev});
      d.chk = chk;
      d.rsp = rsp_word_type'({tg, ld, cm, er});
      return d;
   endfunction

   task automatic send_tick(input req_word_type w, input bit chk, input rsp_word_type typed);
      rsp_word_type pred;
      while (!quiet && $urandom_range(99) < 26) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      {req_current_mode, req_link_up, req_button_click, req_button_double,
       req_button_multi, req_emergency_click, req_sport_mode} = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = decide_tick(w);
      rsp_due_q.push_back(chk ? typed : pred);
      n_ticks++;
      @(negedge clock);
   endtask

   // only written with nothing in flight
   task automatic write_fail_limit(input logic [FailW-1:0] v);
      req_valid = 1'b0;
      while (rsp_due_q.size() != 0) @(negedge clock);
      csr_wdata = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sel_limit = v;
      n_cfg++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      n_fail++;
   endtask

   // result side: random stall, checked on accept
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= !quiet && ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due_q.size() == 0) begin
            $display("%0t ns: unexpected word, actual target %0d led %0d cmd %0d err %0d",
                     $time, rsp_target_mode_out, rsp_led_pattern, rsp_output_command,
                     rsp_error_active);
            n_fail++;
         end else begin
            want = rsp_due_q.pop_front();
            n_checked++;
            if (rsp_output_command == CMD_HOLD) n_hold++;
            if (rsp_error_active) n_latched++;
            if (rsp_target_mode_out !== want.target_mode_out)
               report("target_mode_out", 32'(want.target_mode_out),
                      32'(rsp_target_mode_out));
            if (rsp_led_pattern !== want.led_pattern)
               report("led_pattern", 32'(want.led_pattern), 32'(rsp_led_pattern));
            if (rsp_output_command !== want.output_command)
               report("output_command", 32'(want.output_command),
                      32'(rsp_output_command));
            if (rsp_error_active !== want.error_active)
               report("error_active", 32'(want.error_active), 32'(rsp_error_active));
         end
      end
   end

   initial begin : stimulus
      logic [FailW-1:0] phase_limit [N_PHASES];
      req_word_type     w;
      logic [ModeW-1:0] last_cur;
      bit               sport_on;
      int               r;

      reset = 1'b1;
      req_valid = 1'b0;
      {req_current_mode, req_link_up, req_button_click, req_button_double,
       req_button_multi, req_emergency_click, req_sport_mode} = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      quiet = 1'b0;
      n_fail = 0;
      n_ticks = 0;
      n_checked = 0;
      n_hold = 0;
      n_latched = 0;
      n_cfg = 0;
      sel_target = MODE_NORMAL;
      sel_first = 1'b1;
      sel_waiting = 1'b0;
      sel_remembered = MODE_NONE;
      sel_return = MODE_NONE;
      sel_fails = '0;
      sel_limit = MAX_FAILS_RST;
      last_cur = MODE_NORMAL;
      sport_on = 1'b0;
      phase_limit = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd5, 7'd127, 7'd8, MAX_FAILS_RST};

      // link down, then mode none, then first-run pickup of park
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_NONE, 1,
                              MODE_NORMAL, LED_OFF, CMD_NONE, 0));
      dir_rows.push_back(drow(0, 0, MODE_NONE, EV_LINK, 1,
                              MODE_NORMAL, LED_PENDING, CMD_NONE, 0));
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK, 1,
                              MODE_PARK, LED_PENDING, CMD_NONE, 0));
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK | EV_DBL, 1,
                              MODE_NORMAL, LED_PARK, CMD_NONE, 0));
      // pulse, feedback seen, then a failed tick
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK, 1,
                              MODE_NORMAL, LED_PENDING, CMD_SHORT, 0));
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK, 1,
                              MODE_NORMAL, LED_PENDING, CMD_NONE, 0));
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_LINK | EV_CLICK, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_LINK, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_FAST, EV_LINK, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_FAST, EV_LINK | EV_CLICK, 0, 0, 0, 0, 0));
      // clutch sport: fast with return to normal
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_LINK | EV_SPORT, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_FAST, EV_LINK | EV_SPORT, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_FAST, EV_LINK, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_LINK | EV_EMERG, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_LOCK, EV_LINK | EV_MULTI, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_PARK, EV_LINK | EV_SPORT, 0, 0, 0, 0, 0));
      // mode codes above other
      dir_rows.push_back(drow(0, 0, 3'd6, EV_LINK | EV_DBL, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, 3'd7, EV_ALL, 0, 0, 0, 0, 0));
      dir_rows.push_back(drow(0, 0, MODE_LOCK, EV_LINK | EV_SPORT | EV_MULTI, 0, 0, 0, 0, 0));
      // zero limit: always latched, click still resets to normal
      dir_rows.push_back(drow(1, 7'd0, MODE_FAST, EV_LINK | EV_CLICK, 1,
                              MODE_NORMAL, LED_ERROR, CMD_HOLD, 1));
      dir_rows.push_back(drow(0, 0, MODE_NORMAL, EV_NONE, 1,
                              MODE_NORMAL, LED_ERROR, CMD_NONE, 1));
      dir_rows.push_back(drow(1, FAIL_SAT, MODE_NORMAL, EV_LINK, 1,
                              MODE_NORMAL, LED_OFF, CMD_NONE, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].wr) write_fail_limit(dir_rows[i].lim);
         send_tick(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);
      end
      last_cur = MODE_NORMAL;

      for (int p = 0; p < N_PHASES; p++) begin
         write_fail_limit(phase_limit[p]);
         quiet = (p == 6);
         for (int k = 0; k < PHASE_TICKS; k++) begin
            // mostly a pedal that follows the target, some stuck, some noise
            r = $urandom_range(99);
            if (r < 55)      w.current_mode = sel_target;
            else if (r < 80) w.current_mode = last_cur;
            else if (r < 95) w.current_mode = ModeW'($urandom_range(1, 5));
            else             w.current_mode = ModeW'($urandom_range(0, 7));
            if ($urandom_range(99) < 8) sport_on = !sport_on;
            w.link_up = ($urandom_range(99) < 92);
            w.button_click = ($urandom_range(99) < 12);
            w.button_double = ($urandom_range(99) < 8);
            w.button_multi = ($urandom_range(99) < 6);
            w.emergency_click = ($urandom_range(99) < 5);
            w.sport_mode = sport_on;
            last_cur = w.current_mode;
            send_tick(w, 1'b0, '0);
         end
      end
      req_valid = 1'b0;
      quiet = 1'b0;

      while (rsp_due_q.size() != 0) @(negedge clock);
      repeat (6) @(posedge clock);

      $display("%0d ticks sent, %0d result words checked, %0d limit writes",
               n_ticks, n_checked, n_cfg);
      $display("%0d hold commands, %0d words with the error latched", n_hold, n_latched);
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", n_fail);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
